>>> design/error_diffusion_dither_top_defines.svh
// Assertion macros used by the one asserting file, error_diffusion_dither_top.
`ifndef ERROR_DIFFUSION_DITHER_TOP_DEFINES_SVH
`define ERROR_DIFFUSION_DITHER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define EDD_CHECK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("edd check failed");

// Check that cons holds in the cycle after ante.
`define EDD_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("edd check failed");

`endif

>>> design/edd_pkg.sv
package edd_pkg;

    typedef logic signed [23:0] t_err;
    typedef logic signed [25:0] t_val;

    typedef struct packed {
        logic       capture;
        logic       sum;
        logic       lum_acc;
        logic       quant;
        logic       mul;
        logic       err;
        logic       upd;
        logic       wr2;
        logic [1:0] ch;
    } t_cmd;

    typedef struct packed {
        logic last_col;
        logic last_row;
        logic diff;
        logic gray;
        logic out_busy;
    } t_stat;

    localparam logic [2:0] CFG_LEVELS = 3'd0;
    localparam logic [2:0] CFG_STEP   = 3'd1;
    localparam logic [2:0] CFG_GRAY   = 3'd2;
    localparam logic [2:0] CFG_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_HEIGHT = 3'd4;

    localparam logic signed [47:0] ERR_MAX = 48'sd8388607;
    localparam logic signed [47:0] ERR_MIN = -48'sd8388608;

    function automatic t_err sat24(input logic signed [47:0] v);
        t_err r;
        if (v > ERR_MAX) begin
            r = 24'sh7FFFFF;
        end else if (v < ERR_MIN) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic [16:0] lum_coef(input logic [1:0] ch);
        logic [16:0] r;
        case (ch)
            2'd0:    r = 17'd19661;
            2'd1:    r = 17'd38666;
            2'd2:    r = 17'd7209;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

>>> design/error_diffusion_dither_top.sv
// Channel   Dir  Payload
// s_axis    in   tdata: red[19:0], green[39:20], blue[59:40], zero fill to 64
// m_axis    out  tdata: level_red, level_green, level_blue; tlast: frame_end
// cfg       in   we, addr (register index), wdata (33 bits)
//
// Color mode runs three passes of quantize, multiply, error through the
// shared quantizer and level multiplier; gray mode runs three luminance
// multiply-accumulate steps, one quantize and multiply, three error steps.
// A row end adds a step when the line RAM takes its second write. Reset is
// synchronous, active low; no clearing pass. A pixel is taken while the
// previous result waits; the update step stalls on a full output register.
`include "error_diffusion_dither_top_defines.svh"

module error_diffusion_dither_top #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [32:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // red, green, blue, zero fill
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // level_red, level_green, level_blue
    output logic        o_m_tlast
);

    localparam int CW = $clog2(MAX_WIDTH);

    edd_pkg::t_cmd  w_cmd;
    edd_pkg::t_stat w_stat;

    logic          w_ram_we;
    logic [CW-1:0] w_ram_waddr, w_ram_raddr;
    logic [71:0]   w_ram_wdata, w_ram_rdata;

    edd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    edd_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    edd_ram #(.WIDTH(72), .DEPTH(MAX_WIDTH)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    `EDD_CHECK_NEXT(a_one_at_a_time, i_s_tvalid && o_s_tready, !o_s_tready)
    `EDD_CHECK_NOW(a_out_from_update, $rose(o_m_tvalid), $past(w_cmd.upd))
    `EDD_CHECK_NOW(a_no_overwrite, w_cmd.upd, !(o_m_tvalid && !i_m_tready))

endmodule

>>> design/edd_ram.sv
module edd_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/edd_ctrl.sv
module edd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  edd_pkg::t_stat i_stat,
    output edd_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_LUM  = 3'd2;
    localparam logic [2:0] S_QNT  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_ERR  = 3'd5;
    localparam logic [2:0] S_UPD  = 3'd6;
    localparam logic [2:0] S_WR2  = 3'd7;

    logic [2:0] r_state, n_state;
    logic [1:0] r_ch, n_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= 2'd0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        o_cmd   = '0;
        o_cmd.ch = r_ch;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_ch = 2'd0;
                n_state = i_stat.gray ? S_LUM : S_QNT;
            end
            S_LUM: begin
                o_cmd.lum_acc = 1'b1;
                if (r_ch == 2'd2) begin
                    n_ch = 2'd0;
                    n_state = S_QNT;
                end else begin
                    n_ch = r_ch + 2'd1;
                end
            end
            S_QNT: begin
                o_cmd.quant = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_ERR;
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                if (r_ch == 2'd2) begin
                    n_ch = 2'd0;
                    n_state = S_UPD;
                end else begin
                    n_ch = r_ch + 2'd1;
                    n_state = i_stat.gray ? S_ERR : S_QNT;
                end
            end
            S_UPD: begin
                if (!i_stat.out_busy) begin
                    o_cmd.upd = 1'b1;
                    if (i_stat.diff && !i_stat.last_row && i_stat.last_col) begin
                        n_state = S_WR2;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_WR2: begin
                o_cmd.wr2 = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

>>> design/edd_datapath.sv
module edd_datapath #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [2:0]                   i_cfg_addr,
    input  logic [32:0]                  i_cfg_wdata,
    input  logic [63:0]                  i_s_tdata,
    output logic [47:0]                  o_m_tdata,
    output logic                         o_m_tlast,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    input  edd_pkg::t_cmd                i_cmd,
    output edd_pkg::t_stat               o_stat,
    output logic                         o_ram_we,
    output logic [$clog2(MAX_WIDTH)-1:0] o_ram_waddr,
    output logic [71:0]                  o_ram_wdata,
    output logic [$clog2(MAX_WIDTH)-1:0] o_ram_raddr,
    input  logic [71:0]                  i_ram_rdata
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [15:0] r_levels;
    logic [32:0] r_step;
    logic        r_gray;
    logic [12:0] r_width;
    logic [15:0] r_height;

    logic [CW-1:0] r_col, r_wx;
    logic [15:0]   r_row;

    logic [19:0]         r_in   [3];
    edd_pkg::t_val       r_v    [3];
    edd_pkg::t_err       r_e    [3];
    logic [15:0]         r_code [3];
    edd_pkg::t_err       r_right [3];
    edd_pkg::t_err       r_pbl   [3];
    edd_pkg::t_err       r_dr    [3];
    logic signed [47:0]  r_acc;
    logic [15:0]         r_qcode;
    logic [48:0]         r_prod;

    logic [47:0] r_out_data;
    logic        r_out_last;
    logic        r_out_valid;

    logic [CW:0]   w_weff;
    logic [15:0]   w_heff;
    logic          w_last_col, w_last_row, w_diff;

    always_comb begin
        if (r_width == 13'd0) begin
            w_weff = (CW+1)'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_weff = (CW+1)'(MAX_WIDTH);
        end else begin
            w_weff = (CW+1)'(r_width);
        end
        w_heff = (r_height == 16'd0) ? 16'd1 : r_height;
        w_last_col = ({1'b0, r_col} + (CW+1)'(1)) >= w_weff;
        w_last_row = ({1'b0, r_row} + 17'd1) >= {1'b0, w_heff};
        w_diff = (w_weff >= (CW+1)'(3)) && (w_heff >= 16'd3);
    end

    // Sum stage values
    edd_pkg::t_val w_vnew [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic signed [19:0] s;
            logic [16:0] sc;
            edd_pkg::t_err inc;
            edd_pkg::t_err lin;
            s = $signed(r_in[c]);
            if (s < 0) begin
                sc = 17'd0;
            end else if (s > 20'sd65536) begin
                sc = 17'd65536;
            end else begin
                sc = s[16:0];
            end
            lin = i_ram_rdata[24*c +: 24];
            inc = '0;
            if (w_diff) begin
                inc = edd_pkg::sat24(48'((r_col != '0) ? r_right[c] : 24'sd0)
                                     + 48'((r_row != 16'd0) ? lin : 24'sd0));
            end
            w_vnew[c] = $signed({5'b0, sc, 4'b0}) + 26'(inc);
        end
    end

    edd_pkg::t_val       w_vsel;
    logic [16:0]         w_coef;
    logic signed [43:0]  w_lprod;
    edd_pkg::t_val       w_qin;
    logic signed [42:0]  w_qprod;
    logic signed [44:0]  w_n, w_cu;
    logic [15:0]         w_qcode;
    logic [49:0]         w_m;
    edd_pkg::t_err       w_enew;

    always_comb begin
        w_vsel  = r_v[i_cmd.ch];
        w_coef  = edd_pkg::lum_coef(i_cmd.ch);
        w_lprod = $signed({1'b0, w_coef}) * w_vsel;
        w_qin   = r_gray ? r_acc[41:16] : w_vsel;
        w_qprod = w_qin * $signed({1'b0, r_levels});
        w_n     = (45'(w_qprod) <<< 1) - 45'sd1048576;
        w_cu    = (w_n + 45'sd2097151) >>> 21;
        if (w_n <= 0) begin
            w_qcode = 16'd0;
        end else if (w_cu > $signed({29'b0, r_levels})) begin
            w_qcode = r_levels;
        end else begin
            w_qcode = w_cu[15:0];
        end
        w_m    = 50'(r_prod) + 50'd2048;
        w_enew = edd_pkg::sat24(48'(w_vsel) - $signed({10'b0, w_m[49:12]}));
    end

    // Diffusion parts
    edd_pkg::t_err w_p7 [3], w_p5 [3], w_p3 [3], w_p1 [3], w_np [3], w_bl [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic signed [27:0] t7, t5, t3;
            t7 = 28'(r_e[c]) * 28'sd7;
            t5 = 28'(r_e[c]) * 28'sd5;
            t3 = 28'(r_e[c]) * 28'sd3;
            w_p7[c] = t7[27:4];
            w_p5[c] = t5[27:4];
            w_p3[c] = t3[27:4];
            w_p1[c] = r_e[c] >>> 4;
            w_bl[c] = edd_pkg::sat24(48'(r_pbl[c]) + 48'(w_p3[c]));
            w_np[c] = edd_pkg::sat24(48'((r_col != '0) ? r_dr[c] : 24'sd0) + 48'(w_p5[c]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= 16'd1;
            r_step   <= 33'h1_0000_0000;
            r_gray   <= 1'b0;
            r_width  <= 13'd1;
            r_height <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                edd_pkg::CFG_LEVELS: r_levels <= i_cfg_wdata[15:0];
                edd_pkg::CFG_STEP:   r_step   <= i_cfg_wdata;
                edd_pkg::CFG_GRAY:   r_gray   <= i_cfg_wdata[0];
                edd_pkg::CFG_WIDTH:  r_width  <= i_cfg_wdata[12:0];
                edd_pkg::CFG_HEIGHT: r_height <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_right[c] <= '0;
                r_pbl[c]   <= '0;
                r_dr[c]    <= '0;
            end
        end else begin
            if (i_cmd.upd) begin
                r_out_valid <= 1'b1;
                if (w_last_col) begin
                    r_col <= '0;
                    r_row <= w_last_row ? 16'd0 : r_row + 16'd1;
                end else begin
                    r_col <= r_col + CW'(1);
                end
                if (w_diff) begin
                    for (int c = 0; c < 3; c++) begin
                        r_right[c] <= w_last_col ? 24'sd0 : w_p7[c];
                        if (!w_last_row) begin
                            r_pbl[c] <= w_np[c];
                            r_dr[c]  <= w_last_col ? 24'sd0 : w_p1[c];
                        end
                    end
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in[0] <= i_s_tdata[19:0];
            r_in[1] <= i_s_tdata[39:20];
            r_in[2] <= i_s_tdata[59:40];
        end
        if (i_cmd.sum) begin
            for (int c = 0; c < 3; c++) begin
                r_v[c] <= w_vnew[c];
            end
            r_acc <= 48'sd32768;
        end
        if (i_cmd.lum_acc) begin
            r_acc <= r_acc + 48'(w_lprod);
        end
        if (i_cmd.quant) begin
            r_qcode <= w_qcode;
        end
        if (i_cmd.mul) begin
            r_prod <= r_qcode * r_step;
        end
        if (i_cmd.err) begin
            r_e[i_cmd.ch]    <= w_enew;
            r_code[i_cmd.ch] <= r_qcode;
        end
        if (i_cmd.upd) begin
            r_out_data <= {r_code[2], r_code[1], r_code[0]};
            r_out_last <= w_last_col && w_last_row;
            r_wx       <= r_col;
        end
    end

    always_comb begin
        if (i_cmd.wr2) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = r_wx;
            o_ram_wdata = {r_pbl[2], r_pbl[1], r_pbl[0]};
        end else begin
            o_ram_we    = i_cmd.upd && w_diff && !w_last_row && (r_col != '0);
            o_ram_waddr = r_col - CW'(1);
            o_ram_wdata = {w_bl[2], w_bl[1], w_bl[0]};
        end
    end

    assign o_ram_raddr = r_col;

    assign o_stat.last_col = w_last_col;
    assign o_stat.last_row = w_last_row;
    assign o_stat.diff     = w_diff;
    assign o_stat.gray     = r_gray;
    assign o_stat.out_busy = r_out_valid && !i_m_tready;

    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tvalid = r_out_valid;

endmodule

>>> tb/edd_checker.sv
`timescale 1ns / 1ps

module edd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [32:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,   // red, green, blue, zero fill
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,   // level_red, level_green, level_blue
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int LINE_DEPTH = 4096;

    longint      line_err [LINE_DEPTH][3];
    longint      right_err [3];
    longint      below_left [3];
    longint      below_right [3];
    int unsigned col_q;
    int unsigned row_q;

    logic [15:0] levels_q;
    logic [32:0] step_q;
    logic        gray_q;
    logic [12:0] width_q;
    logic [15:0] height_q;

    logic [48:0] levels_due [$];

    function automatic longint clip24(input longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic longint share(input longint e, input longint w);
        return clip24((e * w) >>> 4);
    endfunction

    function automatic longint level_code(input longint v);
        longint n;
        longint k;
        n = 2 * v * longint'(levels_q) - (64'sd1 << 20);
        if (n <= 0) return 0;
        k = (n + ((64'sd1 << 21) - 1)) >>> 21;
        if (k > longint'(levels_q)) k = longint'(levels_q);
        return k;
    endfunction

    function automatic longint level_value(input longint k);
        longint p;
        p = k * longint'(step_q);
        return (p + 2048) >>> 12;
    endfunction

    task automatic dither_pixel(input logic [63:0] d, output logic [48:0] res);
        int unsigned wd;
        int unsigned ht;
        int unsigned x;
        int unsigned y;
        bit          lc;
        bit          lr;
        bit          df;
        longint      v [3];
        longint      e [3];
        longint      k [3];
        longint      s;
        longint      inc;
        longint      lum;
        longint      m;
        longint      np;
        logic [19:0] raw;
        wd = width_q;
        ht = height_q;
        x = col_q;
        y = row_q;
        if (wd < 1) wd = 1;
        if (wd > LINE_DEPTH) wd = LINE_DEPTH;
        if (ht < 1) ht = 1;
        lc = (x + 1 >= wd);
        lr = (y + 1 >= ht);
        df = (wd >= 3) && (ht >= 3);
        for (int c = 0; c < 3; c++) begin
            raw = d[c*20 +: 20];
            s = longint'($signed(raw));
            inc = 0;
            if (s < 0) s = 0;
            if (s > 65536) s = 65536;
            if (df) begin
                if (x > 0) inc += right_err[c];
                if (y > 0 && x < LINE_DEPTH) inc += line_err[x][c];
                inc = clip24(inc);
            end
            v[c] = s * 16 + inc;
        end
        if (gray_q) begin
            lum = (19661 * v[0] + 38666 * v[1] + 7209 * v[2] + 32768) >>> 16;
            k[0] = level_code(lum);
            m = level_value(k[0]);
            for (int c = 0; c < 3; c++) begin
                k[c] = k[0];
                e[c] = clip24(v[c] - m);
            end
        end else begin
            for (int c = 0; c < 3; c++) begin
                k[c] = level_code(v[c]);
                e[c] = clip24(v[c] - level_value(k[c]));
            end
        end
        if (df) begin
            for (int c = 0; c < 3; c++) begin
                right_err[c] = lc ? 0 : share(e[c], 7);
                if (!lr) begin
                    if (x > 0 && x - 1 < LINE_DEPTH)
                        line_err[x-1][c] = clip24(below_left[c] + share(e[c], 3));
                    np = clip24((x > 0 ? below_right[c] : 0) + share(e[c], 5));
                    below_right[c] = lc ? 0 : share(e[c], 1);
                    below_left[c] = np;
                    if (lc && x < LINE_DEPTH) line_err[x][c] = np;
                end
            end
        end
        res = {lc && lr, k[2][15:0], k[1][15:0], k[0][15:0]};
        if (lc) begin
            col_q = 0;
            row_q = lr ? 0 : y + 1;
        end else begin
            col_q = x + 1;
        end
    endtask

    always @(posedge i_clk) begin
        logic [48:0] res;
        logic [48:0] want;
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                right_err[c] = 0;
                below_left[c] = 0;
                below_right[c] = 0;
            end
            col_q = 0;
            row_q = 0;
            levels_q = 16'd1;
            step_q = 33'h1_0000_0000;
            gray_q = 1'b0;
            width_q = 13'd1;
            height_q = 16'd1;
            levels_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    edd_pkg::CFG_LEVELS: levels_q = i_cfg_wdata[15:0];
                    edd_pkg::CFG_STEP:   step_q = i_cfg_wdata;
                    edd_pkg::CFG_GRAY:   gray_q = i_cfg_wdata[0];
                    edd_pkg::CFG_WIDTH:  width_q = i_cfg_wdata[12:0];
                    edd_pkg::CFG_HEIGHT: height_q = i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                dither_pixel(i_s_tdata, res);
                levels_due.push_back(res);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (levels_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result: tlast %0b tdata %h", i_m_tlast, i_m_tdata);
                end else begin
                    want = levels_due.pop_front();
                    if ({i_m_tlast, i_m_tdata} !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: r %0d/%0d g %0d/%0d b %0d/%0d last %0b/%0b",
                                     want[15:0], i_m_tdata[15:0], want[31:16],
                                     i_m_tdata[31:16], want[47:32], i_m_tdata[47:32],
                                     want[48], i_m_tlast);
                    end
                end
            end
        end
        o_pending = levels_due.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam logic [2:0] CFG_SPARE = 3'd5;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 30;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [32:0] i_cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending;

    int          send_idle_pct;
    int          recv_stall_pct;
    bit          long_hold_req;
    int          hold_left;
    int          quiet_cycles;
    int          pixels_sent;

    error_diffusion_dither_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast)
    );

    edd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (long_hold_req && hold_left == 0) begin
            hold_left = 400;
            long_hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic logic [19:0] pick_sample();
        case ($urandom_range(9))
            0, 1:    return 20'($urandom);
            2:       return 20'd0;
            3:       return 20'd65536;
            default: return 20'($urandom_range(65536));
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [32:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic setup(input int levels, input logic [32:0] step, input bit gray,
                         input int wd, input int ht);
        settle();
        write_reg(edd_pkg::CFG_LEVELS, 33'(levels));
        write_reg(edd_pkg::CFG_STEP, step);
        write_reg(edd_pkg::CFG_GRAY, 33'(gray));
        write_reg(edd_pkg::CFG_WIDTH, 33'(wd));
        write_reg(edd_pkg::CFG_HEIGHT, 33'(ht));
    endtask

    task automatic send_pixel(input logic [19:0] r, input logic [19:0] g,
                              input logic [19:0] b);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, b, g, r};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        pixels_sent++;
    endtask

    task automatic send_image(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(pick_sample(), pick_sample(), pick_sample());
        s_tvalid <= 1'b0;
    endtask

    function automatic logic [32:0] step_for(input int levels);
        return 33'(((64'd1 << 32) + levels / 2) / levels);
    endfunction

    task automatic set_phase(input int sel);
        case (sel % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
        endcase
    endtask

    initial begin
        logic [19:0] corner [8];
        int          lv;
        int          wd;
        int          ht;
        int          img;
        logic [32:0] st;
        corner = '{20'h80000, 20'h7FFFF, 20'd0, 20'd65536, 20'd32768, 20'd32767,
                   20'hFFFFF, 20'd65537};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = edd_pkg::CFG_LEVELS;
        i_cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold_req = 0;
        hold_left = 0;
        quiet_cycles = 0;
        pixels_sent = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        setup(1, 33'h1_0000_0000, 0, 3, 3);
        for (int i = 0; i < 9; i++)
            send_pixel(corner[i % 8], corner[(i + 3) % 8], corner[(i + 5) % 8]);
        setup(1, 33'h1_0000_0000, 1, 3, 3);
        for (int i = 0; i < 9; i++)
            send_pixel(corner[(i + 1) % 8], corner[(i + 6) % 8], corner[i % 8]);
        setup(65535, 33'd65537, 0, 4, 3);
        send_image(12);
        setup(0, 33'd12345, 0, 0, 0);
        write_reg(CFG_SPARE, 33'h1_FFFF_FFFF);
        send_image(3);
        setup(7, 33'h1_FFFF_FFFF, 1, 2, 65535);
        send_image(4);
        settle();
        write_reg(edd_pkg::CFG_WIDTH, 33'd1);
        write_reg(edd_pkg::CFG_HEIGHT, 33'd1);
        send_image(1);

        img = 0;
        while (pixels_sent < 1000) begin
            case ($urandom_range(9))
                0:       lv = 65535;
                1:       lv = 1;
                2:       lv = $urandom_range(65535, 1);
                default: lv = $urandom_range(16, 1);
            endcase
            st = ($urandom_range(7) == 0) ? 33'($urandom_range(32'hFFFF_FFFF, 65537))
                                          : step_for(lv);
            wd = ($urandom_range(7) == 0) ? $urandom_range(2, 1) : $urandom_range(12, 3);
            ht = ($urandom_range(7) == 0) ? $urandom_range(2, 1) : $urandom_range(6, 3);
            setup(lv, st, $urandom_range(1), wd, ht);
            set_phase(img);
            if (img == 5) long_hold_req = 1;
            send_image(wd * ht);
            img++;
        end

        settle();
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
